// ===== src/mme_pkg.sv =====
package mme_pkg;

  // Width of every payload port.
  localparam int FIELD_WIDTH = 64;

  // Default operand width; only the low bits of each field are used.
  localparam int OPERAND_WIDTH_DEFAULT = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LAUNCH,
    ST_MULT,
    ST_FINISH
  } state_t;

endpackage

// ===== src/mme_modred.sv =====
// Bit-serial restoring reduction: remainder = dividend mod m, one bit per cycle.
module mme_modred #(
  parameter int W = mme_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  rem;
  logic [W-1:0]  dreg;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W:0]    trial;
  logic [W:0]    trial_diff;

  // Shift in the next dividend bit, subtract the modulus if it fits.
  assign trial      = {rem, dreg[W-1]};
  assign trial_diff = trial - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        rem     <= '0;
        dreg    <= dividend;
        cnt     <= '0;
      end else if (running) begin
        rem  <= (trial >= {1'b0, m}) ? trial_diff[W-1:0] : trial[W-1:0];
        dreg <= {dreg[W-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

// ===== src/mme_modmul.sv =====
// Bit-serial modular multiplier: product = x * y mod m, x and y below m.
// Scans y from its top bit; each bit takes a doubling step and then an add step.
module mme_modmul #(
  parameter int W = mme_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] product
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  acc;
  logic [W-1:0]  yreg;
  logic [CW-1:0] cnt;
  logic          phase;
  logic          running;
  logic [W:0]    dbl_sum;
  logic [W:0]    dbl_diff;
  logic [W:0]    add_sum;
  logic [W:0]    add_diff;
  logic [W-1:0]  dbl_mod;
  logic [W-1:0]  add_mod;

  // A separate add and compare path per phase; carry kept in the extra bit.
  assign dbl_sum  = {1'b0, acc} + {1'b0, acc};
  assign dbl_diff = dbl_sum - {1'b0, m};
  assign dbl_mod  = (dbl_sum >= {1'b0, m}) ? dbl_diff[W-1:0] : dbl_sum[W-1:0];
  assign add_sum  = {1'b0, acc} + {1'b0, x};
  assign add_diff = add_sum - {1'b0, m};
  assign add_mod  = (add_sum >= {1'b0, m}) ? add_diff[W-1:0] : add_sum[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        phase   <= 1'b0;
        cnt     <= '0;
        acc     <= '0;
        yreg    <= y;
      end else if (running) begin
        if (!phase) begin
          acc   <= dbl_mod;
          phase <= 1'b1;
        end else begin
          if (yreg[W-1]) begin
            acc <= add_mod;
          end
          yreg  <= {yreg[W-2:0], 1'b0};
          phase <= 1'b0;
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  assign product = acc;

endmodule

// ===== src/modular_exponentiation_top.sv =====
// Modular exponentiation, right-to-left square-and-multiply: power_result =
// base_value ^ exponent_value mod modulus_value, on the low OPERAND_WIDTH bits
// of each field. A transfer in happens at a rising edge with start high and
// busy low; busy then stays high until the result has been shown. The result
// is flagged by done, high for exactly one cycle, and the receiver
// cannot stall it: sample it in that cycle or lose it. A zero exponent
// returns 1 (unreduced, even for modulus 1) and a zero modulus with a
// nonzero exponent returns 0, both with done high in the cycle right after
// the transfer. Otherwise the base is first reduced by a bit-serial
// divider, then every exponent bit up to the highest set one costs one pass
// of two bit-serial modular multipliers running side by side.
module modular_exponentiation_top #(
  parameter int OPERAND_WIDTH = mme_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  output logic                            done,
  input  logic [mme_pkg::FIELD_WIDTH-1:0] base_value,
  input  logic [mme_pkg::FIELD_WIDTH-1:0] exponent_value,
  input  logic [mme_pkg::FIELD_WIDTH-1:0] modulus_value,
  output logic [mme_pkg::FIELD_WIDTH-1:0] power_result
);

  import mme_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_t state, state_next;

  // Working registers: current base power, running product, modulus and
  // the exponent bits not yet consumed.
  logic [W-1:0]           base_pow;
  logic [W-1:0]           acc;
  logic [W-1:0]           modulus;
  logic [W-1:0]           expo;
  logic [FIELD_WIDTH-1:0] result;

  logic         red_start, red_done;
  logic [W-1:0] red_rem;
  logic         mul_start;
  logic         mul_done, sq_done;
  logic [W-1:0] mul_prod, sq_prod;
  logic [W-1:0] acc_upd;
  logic         accept;

  logic [W-1:0] base_in, expo_in, mod_in;

  assign base_in = base_value[W-1:0];
  assign expo_in = exponent_value[W-1:0];
  assign mod_in  = modulus_value[W-1:0];

  assign accept = start && !busy;

  // Take the multiply result only when the current exponent bit is set.
  assign acc_upd = expo[0] ? mul_prod : acc;

  // Reduce the base modulo the modulus before the power loop.
  mme_modred #(.W(W)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .start     (red_start),
    .dividend  (base_pow),
    .m         (modulus),
    .done      (red_done),
    .remainder (red_rem)
  );

  // Running product times base power.
  mme_modmul #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (acc),
    .y       (base_pow),
    .m       (modulus),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Base power squared; runs in lockstep with the multiply.
  mme_modmul #(.W(W)) u_square (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (base_pow),
    .y       (base_pow),
    .m       (modulus),
    .done    (sq_done),
    .product (sq_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit strobes.
  always_comb begin
    state_next = state;
    red_start  = 1'b0;
    mul_start  = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (expo_in == '0 || mod_in == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // Load the divider on the first cycle here; drop the strobe once it
        // ends so it does not start over.
        red_start = !red_done;
        if (red_done) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        mul_start  = 1'b1;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        if (mul_done && sq_done) begin
          state_next = (expo[W-1:1] == '0) ? ST_FINISH : ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          base_pow <= base_in;
          modulus  <= mod_in;
          expo     <= expo_in;
          if (expo_in == '0) begin
            result <= FIELD_WIDTH'(1);
          end else begin
            result <= '0;
          end
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          base_pow <= red_rem;
          // Starting product 1 is already reduced unless the modulus is 1.
          acc      <= (modulus == W'(1)) ? '0 : W'(1);
        end
      end
      ST_MULT: begin
        if (mul_done && sq_done) begin
          acc      <= acc_upd;
          base_pow <= sq_prod;
          expo     <= {1'b0, expo[W-1:1]};
          result   <= FIELD_WIDTH'(acc_upd);
        end
      end
      default: begin
      end
    endcase
  end

  assign power_result = result;

endmodule
